/* rtl/core/cdf_pkg.sv */
// Shared constants, command codes and sizes for the decouple-to-float block.
// No dependencies.
package cdf_pkg;
  localparam int NUM_BINS         = 256;
  localparam int NUM_CHANNELS     = 5;
  localparam int NUM_SUBBANDS     = 18;
  localparam int BINS_PER_SUBBAND = 12;
  // (d * RECIP) >> RECIP_SHIFT equals d / 12 for every 8-bit d
  localparam int RECIP            = 171;
  localparam int RECIP_SHIFT      = 11;

  localparam int COORD_DEPTH = NUM_CHANNELS * NUM_SUBBANDS;
  localparam int COORD_AW    = $clog2(COORD_DEPTH);
  localparam int BIN_AW      = $clog2(NUM_BINS);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;
  localparam logic [CFG_IDX_W-1:0] CFG_CPL_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_STR  = 2'd1;

  typedef enum logic [1:0] {
    CMD_CONVERT  = 2'd0,
    CMD_LOAD_CPL = 2'd1,
    CMD_LOAD_CRD = 2'd2,
    CMD_DECOUPLE = 2'd3
  } cmd_e;
endpackage

/* rtl/core/cdf_if.sv */
// Word channels of the decouple-to-float block: input items and results.
// No dependencies.
interface cdf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [2:0] channel;
  logic [7:0] bin;
  logic [4:0] subband;
  logic [4:0] exponent;
  logic [15:0] mantissa;
  logic [3:0] coord_exp;
  logic [3:0] coord_mant;
  logic [1:0] master_coord;
  modport source (output valid, cmd, channel, bin, subband, exponent, mantissa,
                  coord_exp, coord_mant, master_coord, input ready);
  modport sink (input valid, cmd, channel, bin, subband, exponent, mantissa,
                coord_exp, coord_mant, master_coord, output ready);
endinterface

interface cdf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic [2:0]  out_channel;
  logic [7:0]  out_bin;
  modport source (output valid, value, out_channel, out_bin, input ready);
  modport sink (input valid, value, out_channel, out_bin, output ready);
endinterface

/* rtl/core/coupling_decouple_to_float.sv */
// Top level: exponent/mantissa to IEEE single conversion and coupling decouple.
// Depends on cdf_pkg, cdf_if (cdf_in_if, cdf_out_if) and cdf_ram.
//
// Usage:
//   in_i carries one command word: convert (emit a float), load a coupling
//   coefficient by bin, load a coupling coordinate by channel and subband,
//   or decouple (emit coordinate times stored coefficient). out_o carries
//   one result word for convert and decouple; loads produce none.
//   Registers cpl_start_bin and band_structure are written on cfg_we_i.
// Sequence:
//   One word is in flight at a time. A load is written in S_EXEC; convert
//   goes through S_EXEC and S_DONE, decouple through S_EXEC, S_MUL (the
//   registered 24x24 significand multiply) and S_DONE; both RAMs are read,
//   registered, as the word is accepted. in_i.ready is high when idle.
// Reset:
//   rst_ni clears control state and sets cpl_start_bin to 37 and
//   band_structure to 0. RAM contents are undefined until written.
// Stall:
//   A finished result waits in the output register. A new word is accepted
//   meanwhile; its result holds in a finish state until the slot frees.
module coupling_decouple_to_float
  import cdf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  cdf_in_if.sink                in_i,
  cdf_out_if.source             out_o
);
  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_MUL, S_DONE} state_e;

  function automatic logic [31:0] make_float(input logic [4:0] e, input logic [15:0] m);
    logic [15:0] mm;
    logic [15:0] mag;
    logic        sgn;
    logic [4:0]  sh;
    logic [7:0]  biased;
    logic [38:0] t;
    mm  = (m == 16'h8000) ? 16'h8001 : m;
    sgn = mm[15];
    mag = sgn ? (~mm + 16'd1) : mm;
    mag = {mag[14:0], 1'b0};
    sh  = 5'd16;
    for (int i = 0; i < 16; i++) begin
      if (mag[i]) sh = 5'(16 - i);
    end
    biased = 8'd127 - {3'b0, e} - {3'b0, sh};
    t = {23'b0, mag} << (6'd7 + {1'b0, sh});
    return (m == 16'h0) ? 32'h0 : {sgn, biased, t[22:0]};
  endfunction

  // Configuration registers
  logic [7:0]  cpl_start_q;
  logic [17:0] band_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpl_start_q <= 8'd37;
      band_q      <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_CPL_START) cpl_start_q <= cfg_data_i[7:0];
      else if (cfg_idx_i == CFG_BAND_STR) band_q <= cfg_data_i;
    end
  end

  state_e state_q;
  logic   accept;
  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  // Address decode on the incoming word
  logic [7:0]          diff;
  logic [15:0]         band_prod;
  logic [4:0]          band;
  logic [7:0]          crd_idx_full;
  logic [7:0]          dec_idx_full;
  logic                ld_ok, dec_ok, reuse;
  logic [COORD_AW-1:0] crd_raddr;

  assign diff      = in_i.bin - cpl_start_q;
  assign band_prod = 16'(diff) * 16'(RECIP);
  assign band      = 5'(band_prod >> RECIP_SHIFT);
  assign crd_idx_full = 8'(in_i.channel) * 8'(NUM_SUBBANDS) + 8'(in_i.subband);
  assign dec_idx_full = 8'(in_i.channel) * 8'(NUM_SUBBANDS) + 8'(band);
  assign ld_ok  = (32'(in_i.channel) < NUM_CHANNELS) && (32'(in_i.subband) < NUM_SUBBANDS);
  assign dec_ok = (in_i.bin >= cpl_start_q) && (32'(in_i.bin) < NUM_BINS)
                  && (32'(in_i.channel) < NUM_CHANNELS) && (32'(band) < NUM_SUBBANDS);
  assign reuse  = (in_i.subband != 5'd0) && ((band_q >> in_i.subband) & 18'd1) != 18'd0;
  assign crd_raddr = (cmd_e'(in_i.cmd) == CMD_DECOUPLE) ? COORD_AW'(dec_idx_full)
                                                        : COORD_AW'(crd_idx_full - 8'd1);

  // Held word
  cmd_e                cmd_q;
  logic [2:0]          ch_q;
  logic [7:0]          bin_q;
  logic [4:0]          ex_q;
  logic [15:0]         mant_q;
  logic [3:0]          cexp_q, cmant_q;
  logic [1:0]          master_q;
  logic                ok_q, reuse_q;
  logic [COORD_AW-1:0] widx_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= cmd_e'(in_i.cmd);
      ch_q     <= in_i.channel;
      bin_q    <= in_i.bin;
      ex_q     <= in_i.exponent;
      mant_q   <= in_i.mantissa;
      cexp_q   <= in_i.coord_exp;
      cmant_q  <= in_i.coord_mant;
      master_q <= in_i.master_coord;
      ok_q     <= (cmd_e'(in_i.cmd) == CMD_DECOUPLE) ? dec_ok : ld_ok;
      reuse_q  <= reuse;
      widx_q   <= COORD_AW'(crd_idx_full);
    end
  end

  // Memories
  logic [31:0] cpl_rdata, crd_rdata, mf_val;
  logic        cpl_we, crd_we;
  logic [4:0]  mf_e;
  logic [15:0] mf_m;

  assign cpl_we = (state_q == S_EXEC) && (cmd_q == CMD_LOAD_CPL);
  assign crd_we = (state_q == S_EXEC) && (cmd_q == CMD_LOAD_CRD) && ok_q;

  cdf_ram #(.WIDTH(32), .DEPTH(NUM_BINS)) u_cpl_ram (
    .clk_i   (clk_i),
    .we_i    (cpl_we),
    .waddr_i (BIN_AW'(bin_q)),
    .wdata_i (mf_val),
    .re_i    (accept),
    .raddr_i (BIN_AW'(in_i.bin)),
    .rdata_o (cpl_rdata)
  );

  cdf_ram #(.WIDTH(32), .DEPTH(COORD_DEPTH)) u_crd_ram (
    .clk_i   (clk_i),
    .we_i    (crd_we),
    .waddr_i (widx_q),
    .wdata_i (reuse_q ? crd_rdata : mf_val),
    .re_i    (accept),
    .raddr_i (crd_raddr),
    .rdata_o (crd_rdata)
  );

  // One shared converter: coordinate form for loads of coordinates, exponent and mantissa otherwise
  always_comb begin
    if (cmd_q == CMD_LOAD_CRD) begin
      mf_e = 5'(cexp_q) + 5'(master_q) * 5'd3;
      mf_m = (cexp_q == 4'd15) ? {1'b0, cmant_q, 11'b0} : {2'b01, cmant_q, 10'b0};
    end else begin
      mf_e = ex_q;
      mf_m = mant_q;
    end
  end
  assign mf_val = make_float(mf_e, mf_m);

  // Float product; operands are normal and short, so the product is exact
  logic [47:0] prod_q;
  logic [9:0]  pexp_q;
  logic        psign_q, pzero_q;
  logic [31:0] res_q;
  logic [9:0]  nexp;

  assign nexp = prod_q[47] ? pexp_q + 10'd1 : pexp_q;

  logic        out_valid_q;
  logic [31:0] out_value_q;
  logic [2:0]  out_ch_q;
  logic [7:0]  out_bin_q;
  logic        slot_free;
  assign slot_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // in S_DONE a freed slot is refilled below
      if (out_valid_q && out_o.ready && (state_q != S_DONE)) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (accept) state_q <= S_EXEC;
        S_EXEC: begin
          unique case (cmd_q)
            CMD_CONVERT: begin
              res_q   <= mf_val;
              state_q <= S_DONE;
            end
            CMD_DECOUPLE: begin
              prod_q  <= {24'b0, 1'b1, crd_rdata[22:0]} * {24'b0, 1'b1, cpl_rdata[22:0]};
              pexp_q  <= 10'(crd_rdata[30:23]) + 10'(cpl_rdata[30:23]) - 10'd127;
              psign_q <= crd_rdata[31] ^ cpl_rdata[31];
              pzero_q <= (crd_rdata[30:23] == 8'd0) || (cpl_rdata[30:23] == 8'd0);
              state_q <= S_MUL;
            end
            default: state_q <= S_IDLE;
          endcase
        end
        S_MUL: begin
          if (!ok_q) res_q <= 32'h0;
          else if (pzero_q) res_q <= {psign_q, 31'b0};
          else res_q <= {psign_q, nexp[7:0],
                         prod_q[47] ? prod_q[46:24] : prod_q[45:23]};
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_value_q <= res_q;
            out_ch_q    <= ch_q;
            out_bin_q   <= bin_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.value       = out_value_q;
  assign out_o.out_channel = out_ch_q;
  assign out_o.out_bin     = out_bin_q;
endmodule

/* rtl/core/cdf_ram.sv */
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module cdf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
